// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge while reset is released.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_PROP(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/carpid_pkg.sv =====
// Shared widths, register indexes and types of the cascaded angle/rate PID block.
// Depends on nothing; every other file of the block but assert_macros.svh refers to it by scoped names.
package carpid_pkg;

	localparam int DATA_W      = 16;
	localparam int GAIN_W      = 16;
	localparam int LIM_W       = 15;
	localparam int ERR_W       = 18;
	localparam int RATE_W      = 17;
	localparam int VAL_W       = 19;
	localparam int PROD_W      = GAIN_W + VAL_W;
	localparam int CNT_W       = $clog2(GAIN_W);
	localparam int INT_W       = 16;

	localparam int OUTER_SHIFT = 12;
	localparam int INNER_SHIFT = 8;
	localparam int O_TERM_W    = PROD_W - OUTER_SHIFT;
	localparam int O_ACC_W     = O_TERM_W + 1;
	localparam int O_SUM_W     = O_ACC_W + 1;
	localparam int I_TERM_W    = PROD_W - INNER_SHIFT;
	localparam int I_ACC_W     = I_TERM_W + 1;
	localparam int I_SUM_W     = I_ACC_W + 1;

	localparam int OUTER_INT_LIMIT_DEF = 500;
	localparam int INNER_INT_LIMIT_DEF = 0;
	localparam int DEADBAND_DEF        = 160;
	localparam int SEPARATION_DEF      = 160;
	localparam int OUT_LIMIT_RESET     = 1200;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_OUTER_KP    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OUTER_KI    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OUTER_KD    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUTER_LIMIT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INNER_KP    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_INNER_KI    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_INNER_KD    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_INNER_LIMIT = 3'd7;

	typedef struct packed {
		logic signed [GAIN_W-1:0] outer_kp;
		logic signed [GAIN_W-1:0] outer_ki;
		logic signed [GAIN_W-1:0] outer_kd;
		logic [LIM_W-1:0]         outer_out_limit;
		logic signed [GAIN_W-1:0] inner_kp;
		logic signed [GAIN_W-1:0] inner_ki;
		logic signed [GAIN_W-1:0] inner_kd;
		logic [LIM_W-1:0]         inner_out_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} mul_ctrl_t;

endpackage

// ===== rtl/core/carpid_regs.sv =====
// Configuration registers of the PID block behind an APB-style port.
// Depends on carpid_pkg for the register indexes and the cfg_t type.
module carpid_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [carpid_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [carpid_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [carpid_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                  pready,
	output carpid_pkg::cfg_t                      cfg
);

	carpid_pkg::cfg_t                      cfg_q;
	logic [carpid_pkg::REG_IDX_W-1:0]      idx;
	logic                                  wr_en;

	assign idx    = paddr[carpid_pkg::APB_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outer_kp        <= '0;
			cfg_q.outer_ki        <= '0;
			cfg_q.outer_kd        <= '0;
			cfg_q.outer_out_limit <= carpid_pkg::LIM_W'(carpid_pkg::OUT_LIMIT_RESET);
			cfg_q.inner_kp        <= '0;
			cfg_q.inner_ki        <= '0;
			cfg_q.inner_kd        <= '0;
			cfg_q.inner_out_limit <= carpid_pkg::LIM_W'(carpid_pkg::OUT_LIMIT_RESET);
		end else if (wr_en) begin
			unique case (idx)
				carpid_pkg::REG_OUTER_KP:    cfg_q.outer_kp <= pwdata[carpid_pkg::GAIN_W-1:0];
				carpid_pkg::REG_OUTER_KI:    cfg_q.outer_ki <= pwdata[carpid_pkg::GAIN_W-1:0];
				carpid_pkg::REG_OUTER_KD:    cfg_q.outer_kd <= pwdata[carpid_pkg::GAIN_W-1:0];
				carpid_pkg::REG_OUTER_LIMIT: cfg_q.outer_out_limit <= pwdata[carpid_pkg::LIM_W-1:0];
				carpid_pkg::REG_INNER_KP:    cfg_q.inner_kp <= pwdata[carpid_pkg::GAIN_W-1:0];
				carpid_pkg::REG_INNER_KI:    cfg_q.inner_ki <= pwdata[carpid_pkg::GAIN_W-1:0];
				carpid_pkg::REG_INNER_KD:    cfg_q.inner_kd <= pwdata[carpid_pkg::GAIN_W-1:0];
				carpid_pkg::REG_INNER_LIMIT: cfg_q.inner_out_limit <= pwdata[carpid_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			carpid_pkg::REG_OUTER_KP:    prdata = carpid_pkg::APB_DATA_W'(cfg_q.outer_kp);
			carpid_pkg::REG_OUTER_KI:    prdata = carpid_pkg::APB_DATA_W'(cfg_q.outer_ki);
			carpid_pkg::REG_OUTER_KD:    prdata = carpid_pkg::APB_DATA_W'(cfg_q.outer_kd);
			carpid_pkg::REG_OUTER_LIMIT: prdata = carpid_pkg::APB_DATA_W'(cfg_q.outer_out_limit);
			carpid_pkg::REG_INNER_KP:    prdata = carpid_pkg::APB_DATA_W'(cfg_q.inner_kp);
			carpid_pkg::REG_INNER_KI:    prdata = carpid_pkg::APB_DATA_W'(cfg_q.inner_ki);
			carpid_pkg::REG_INNER_KD:    prdata = carpid_pkg::APB_DATA_W'(cfg_q.inner_kd);
			carpid_pkg::REG_INNER_LIMIT: prdata = carpid_pkg::APB_DATA_W'(cfg_q.inner_out_limit);
			default:                     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/carpid_sermul.sv =====
// Bit-serial signed multiplier: one gain bit per cycle while step is set, shift-and-add.
// Depends on carpid_pkg for the mul_ctrl_t type.
module carpid_sermul #(
	parameter int GW = carpid_pkg::GAIN_W,
	parameter int VW = carpid_pkg::VAL_W
) (
	input  logic                   clk,
	input  carpid_pkg::mul_ctrl_t  ctrl,
	input  logic [GW-1:0]          gain,
	input  logic [VW-1:0]          value,
	output logic [GW+VW-1:0]       prod
);

	logic [VW:0]   hi_q;
	logic [GW-1:0] lo_q;
	logic [VW-1:0] val_q;
	logic [VW:0]   addend;
	logic [VW:0]   sum;
	logic          sub;

	// The gain's sign bit is weighted negatively, so the last step subtracts.
	assign sub    = lo_q[0] & ctrl.last;
	assign addend = lo_q[0] ? {val_q[VW-1], val_q} : '0;
	assign sum    = hi_q + (sub ? ~addend : addend) + (VW+1)'(sub);
	assign prod   = {hi_q[VW-1:0], lo_q};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			hi_q  <= '0;
			lo_q  <= gain;
			val_q <= value;
		end else if (ctrl.step) begin
			hi_q <= {sum[VW], sum[VW:1]};
			lo_q <= {sum[0], lo_q[GW-1:1]};
		end
	end

endmodule

// ===== rtl/core/cascaded_angle_rate_pid.sv =====
// Cascaded angle/rate PID controller, top level.
// Depends on carpid_pkg, carpid_regs and carpid_sermul.
//
// One input item carries a target angle, a measured angle, an angle offset and a gyro rate;
// it yields one result item with the motor drive and the outer loop's rate command.
// The block works on one item at a time. Its result enters the output register in the
// same cycle in which the input side opens again, so no new item is taken before then. The
// three bit-serial multipliers run once for the outer loop and once again for the inner loop.
// The states run in the order ST_IDLE, ST_OLOAD, ST_OMUL, ST_OACC, ST_OCMD, ST_IERR, ST_ILOAD,
// ST_IMUL, ST_IACC and ST_IDRV: loading, multiplying, summing and clamping, and the idle state
// in which the next item is accepted. A result waiting in the output register does not hold
// back the next input item, only the delivery of the one after it.
// Configuration registers may be written only while no item is in flight.
module cascaded_angle_rate_pid #(
	parameter int OUTER_INT_LIMIT = carpid_pkg::OUTER_INT_LIMIT_DEF,
	parameter int INNER_INT_LIMIT = carpid_pkg::INNER_INT_LIMIT_DEF,
	parameter int DEADBAND        = carpid_pkg::DEADBAND_DEF,
	parameter int SEPARATION      = carpid_pkg::SEPARATION_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// target_angle, measured_angle, angle_offset, gyro_rate
	input  logic [4*carpid_pkg::DATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// drive, rate_command
	output logic [2*carpid_pkg::DATA_W-1:0]   m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [carpid_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [carpid_pkg::APB_DATA_W-1:0] pwdata,
	output logic [carpid_pkg::APB_DATA_W-1:0] prdata,
	output logic                              pready
);

	localparam int DW  = carpid_pkg::DATA_W;
	localparam int EW  = carpid_pkg::ERR_W;
	localparam int RW  = carpid_pkg::RATE_W;
	localparam int VW  = carpid_pkg::VAL_W;
	localparam int PW  = carpid_pkg::PROD_W;
	localparam int IW  = carpid_pkg::INT_W;
	localparam int OTW = carpid_pkg::O_TERM_W;
	localparam int OAW = carpid_pkg::O_ACC_W;
	localparam int OSW = carpid_pkg::O_SUM_W;
	localparam int ITW = carpid_pkg::I_TERM_W;
	localparam int IAW = carpid_pkg::I_ACC_W;
	localparam int ISW = carpid_pkg::I_SUM_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_OLOAD = 4'd1;
	localparam logic [3:0] ST_OMUL  = 4'd2;
	localparam logic [3:0] ST_OACC  = 4'd3;
	localparam logic [3:0] ST_OCMD  = 4'd4;
	localparam logic [3:0] ST_IERR  = 4'd5;
	localparam logic [3:0] ST_ILOAD = 4'd6;
	localparam logic [3:0] ST_IMUL  = 4'd7;
	localparam logic [3:0] ST_IACC  = 4'd8;
	localparam logic [3:0] ST_IDRV  = 4'd9;

	localparam logic signed [OAW-1:0] O_INT_LIM = OAW'(OUTER_INT_LIMIT);
	localparam logic signed [IAW-1:0] I_INT_LIM = IAW'(INNER_INT_LIMIT);
	localparam logic signed [EW:0]    DB_LIM    = (EW+1)'(DEADBAND);
	localparam logic signed [EW:0]    SEP_LIM   = (EW+1)'(SEPARATION);

	carpid_pkg::cfg_t       cfg;
	carpid_pkg::mul_ctrl_t  mul_ctrl;

	logic [3:0]                          state_q;
	logic [carpid_pkg::CNT_W-1:0]        cnt_q;
	logic                                m_valid_q;
	logic signed [DW-1:0]                drive_q;
	logic signed [DW-1:0]                rate_q;

	logic signed [EW-1:0]  e_q;
	logic signed [DW-1:0]  gyro_q;
	logic signed [EW-1:0]  oprev_q;
	logic signed [IW-1:0]  oint_q;
	logic signed [IW-1:0]  ipart_q;
	logic signed [OAW-1:0] pd_q;
	logic signed [DW-1:0]  cmd_q;
	logic signed [RW-1:0]  f_q;
	logic signed [RW-1:0]  iprev_q;
	logic signed [IW-1:0]  iint_q;
	logic signed [IW-1:0]  i2_q;
	logic signed [IAW-1:0] pd2_q;

	logic [carpid_pkg::GAIN_W-1:0] gain_v [3];
	logic [VW-1:0]                 val_v  [3];
	logic [PW-1:0]                 prod_v [3];

	logic signed [DW-1:0]  in_target;
	logic signed [DW-1:0]  in_measured;
	logic signed [DW-1:0]  in_offset;
	logic signed [EW-1:0]  e_in;
	logic                  outer_ph;
	logic                  take_in;
	logic                  load_out;

	logic signed [OTW-1:0] o_p;
	logic signed [OTW-1:0] o_i;
	logic signed [OTW-1:0] o_d;
	logic signed [OAW-1:0] o_acc;
	logic signed [OAW-1:0] o_acc_c;
	logic signed [OAW-1:0] o_pd;
	logic                  sep;
	logic signed [OSW-1:0] o_sum;
	logic signed [OSW-1:0] o_lim;
	logic signed [DW-1:0]  cmd;
	logic                  in_db;
	logic signed [RW-1:0]  f_in;

	logic signed [ITW-1:0] i_p;
	logic signed [ITW-1:0] i_i;
	logic signed [ITW-1:0] i_d;
	logic signed [IAW-1:0] i_acc;
	logic signed [IAW-1:0] i_acc_c;
	logic signed [IAW-1:0] i_pd;
	logic signed [ISW-1:0] i_sum;
	logic signed [ISW-1:0] i_lim;
	logic signed [DW-1:0]  drive;

	carpid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign outer_ph = (state_q == ST_OLOAD);

	assign mul_ctrl.load = (state_q == ST_OLOAD) || (state_q == ST_ILOAD);
	assign mul_ctrl.step = (state_q == ST_OMUL) || (state_q == ST_IMUL);
	assign mul_ctrl.last = (cnt_q == carpid_pkg::CNT_W'(carpid_pkg::GAIN_W - 1));

	assign gain_v[0] = outer_ph ? cfg.outer_kp : cfg.inner_kp;
	assign gain_v[1] = outer_ph ? cfg.outer_ki : cfg.inner_ki;
	assign gain_v[2] = outer_ph ? cfg.outer_kd : cfg.inner_kd;
	assign val_v[0]  = outer_ph ? VW'(e_q) : VW'(f_q);
	assign val_v[1]  = val_v[0];
	assign val_v[2]  = outer_ph ? VW'(e_q) - VW'(oprev_q) : VW'(iprev_q) - VW'(f_q);

	for (genvar g = 0; g < 3; g++) begin : g_lane
		carpid_sermul #(
			.GW (carpid_pkg::GAIN_W),
			.VW (VW)
		) u_mul (
			.clk   (clk),
			.ctrl  (mul_ctrl),
			.gain  (gain_v[g]),
			.value (val_v[g]),
			.prod  (prod_v[g])
		);
	end

	assign in_target   = s_tdata[DW-1:0];
	assign in_measured = s_tdata[2*DW-1:DW];
	assign in_offset   = s_tdata[3*DW-1:2*DW];
	assign e_in        = EW'(in_target) - EW'(in_measured) - EW'(in_offset);

	assign s_tready = (state_q == ST_IDLE);
	assign take_in  = s_tvalid & s_tready;
	assign load_out = (state_q == ST_IDRV) && (!m_valid_q || m_tready);

	// Outer loop: the integral is updated and added only at or below the separation bound.
	assign o_p     = prod_v[0][PW-1:carpid_pkg::OUTER_SHIFT];
	assign o_i     = prod_v[1][PW-1:carpid_pkg::OUTER_SHIFT];
	assign o_d     = prod_v[2][PW-1:carpid_pkg::OUTER_SHIFT];
	assign o_acc   = OAW'(oint_q) + OAW'(o_i);
	assign o_acc_c = (o_acc > O_INT_LIM) ? O_INT_LIM :
	                 (o_acc < -O_INT_LIM) ? -O_INT_LIM : o_acc;
	assign o_pd    = OAW'(o_p) + OAW'(o_d);
	assign sep     = ((EW+1)'(e_q) <= SEP_LIM);

	assign o_sum = OSW'(pd_q) + OSW'(ipart_q);
	assign o_lim = OSW'(cfg.outer_out_limit);
	assign in_db = ((EW+1)'(e_q) < DB_LIM) && ((EW+1)'(e_q) > -DB_LIM);
	always_comb begin
		if (in_db) begin
			cmd = '0;
		end else if (o_sum > o_lim) begin
			cmd = DW'(o_lim);
		end else if (o_sum < -o_lim) begin
			cmd = DW'(-o_lim);
		end else begin
			cmd = DW'(o_sum);
		end
	end

	assign f_in = RW'(cmd_q) - RW'(gyro_q);

	// Inner loop: the derivative runs on the previous minus the current error.
	assign i_p     = prod_v[0][PW-1:carpid_pkg::INNER_SHIFT];
	assign i_i     = prod_v[1][PW-1:carpid_pkg::INNER_SHIFT];
	assign i_d     = prod_v[2][PW-1:carpid_pkg::INNER_SHIFT];
	assign i_acc   = IAW'(iint_q) + IAW'(i_i);
	assign i_acc_c = (i_acc > I_INT_LIM) ? I_INT_LIM :
	                 (i_acc < -I_INT_LIM) ? -I_INT_LIM : i_acc;
	assign i_pd    = IAW'(i_p) + IAW'(i_d);

	assign i_sum = ISW'(pd2_q) + ISW'(i2_q);
	assign i_lim = ISW'(cfg.inner_out_limit);
	assign drive = (i_sum > i_lim) ? DW'(i_lim) :
	               (i_sum < -i_lim) ? DW'(-i_lim) : DW'(i_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
			oint_q    <= '0;
			oprev_q   <= '0;
			iint_q    <= '0;
			iprev_q   <= '0;
		end else begin
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_OLOAD;
					end
				end
				ST_OLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_OMUL;
				end
				ST_OMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (mul_ctrl.last) begin
						state_q <= ST_OACC;
					end
				end
				ST_OACC: begin
					if (sep) begin
						oint_q <= IW'(o_acc_c);
					end
					oprev_q <= e_q;
					state_q <= ST_OCMD;
				end
				ST_OCMD: state_q <= ST_IERR;
				ST_IERR: state_q <= ST_ILOAD;
				ST_ILOAD: begin
					cnt_q   <= '0;
					iprev_q <= f_q;
					state_q <= ST_IMUL;
				end
				ST_IMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (mul_ctrl.last) begin
						state_q <= ST_IACC;
					end
				end
				ST_IACC: begin
					iint_q  <= IW'(i_acc_c);
					state_q <= ST_IDRV;
				end
				ST_IDRV: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			e_q    <= e_in;
			gyro_q <= s_tdata[4*DW-1:3*DW];
		end
		case (state_q)
			ST_OACC: begin
				ipart_q <= sep ? IW'(o_acc_c) : '0;
				pd_q    <= o_pd;
			end
			ST_OCMD: cmd_q <= cmd;
			ST_IERR: f_q   <= f_in;
			ST_IACC: begin
				i2_q  <= IW'(i_acc_c);
				pd2_q <= i_pd;
			end
			default: ;
		endcase
		if (load_out) begin
			drive_q <= drive;
			rate_q  <= cmd_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {rate_q, drive_q};

endmodule

// ===== rtl/core/carpid_checker.sv =====
// Port-level checker for the cascaded angle/rate PID block, bound to the top level.
// Depends on carpid_pkg and on the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module carpid_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [2*carpid_pkg::DATA_W-1:0]   m_tdata
);

	// A result that is not taken stays on the port unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Output item changed while stalled")

	// Items are worked one at a time, so acceptance closes the input side.
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready, "Input accepted again straight after an item")

	// The serial multipliers keep the input side closed for a long stretch.
	`ASSERT_PROP(a_busy_long, clk, arst_n, (s_tvalid && s_tready) |-> ##20 !s_tready, "Input side reopened too early")

	// A fresh result appears exactly when the block turns idle again.
	`ASSERT_PROP(a_result_frees, clk, arst_n, $rose(m_tvalid) |-> $rose(s_tready), "Result appeared without the block going idle")

endmodule

bind cascaded_angle_rate_pid carpid_checker u_carpid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
